### hdl/htp_pkg.sv
// Shared types, codes and constants for the two-probe hash table core.
package htp_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam int KEY_W = 31;
  localparam int SIZE_W = 5;
  localparam int IDX_W = 4;
  localparam logic [SIZE_W-1:0] SIZE_RST = 5'd13;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_SEARCH = 2'd1,
    CMD_REMOVE = 2'd2
  } cmd_code_t;

  typedef enum logic [1:0] {
    ST_EMPTY    = 2'd0,
    ST_OCCUPIED = 2'd1,
    ST_DELETED  = 2'd2
  } slot_st_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_RD0,
    S_CHK0,
    S_RD1,
    S_CHK1,
    S_FIN
  } state_t;

  typedef struct packed {
    logic [1:0]       command;
    logic [KEY_W-1:0] key;
  } htp_in_t;

  typedef struct packed {
    logic             success;
    logic [IDX_W-1:0] slot_index;
  } htp_out_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic rd_en;
    logic probe_alt;
    logic chk;
    logic out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic div_last;
    logic hit;
  } dp_stat_t;

endpackage

### hdl/hash_table_two_probe_core.sv
// Top level of the two-probe open-addressing hash set.
// One item at a time: an accepted item goes through the bit-serial key mod
// table_size unit (one key bit per cycle), then up to two read-and-check steps
// on the key RAM (the second only when the home slot does not decide it), and
// then the output register is loaded once the output is free. A following
// item can be accepted only after that. The status of every slot is cleared
// by reset at once, so there is no clearing pass. table_size may be written
// only while idle.
module hash_table_two_probe_core import htp_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  htp_in_t           in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output htp_out_t          out_data,
  input  logic              cfg_we,
  input  logic [SIZE_W-1:0] cfg_wdata
);

  ctl_cmd_t ctl;
  dp_stat_t dps;

  htp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cmd      (ctl),
    .st       (dps)
  );

  htp_dp #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .cmd      (ctl),
    .st       (dps)
  );

endmodule

### hdl/htp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module htp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/htp_ctrl.sv
// Sequencing state machine: accept, divide, up to two probes, result hand-off.
module htp_ctrl import htp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  output ctl_cmd_t  cmd,
  input  dp_stat_t  st
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DIV;
      end
      S_DIV: begin
        if (st.div_last) state_nxt = S_RD0;
      end
      S_RD0:  state_nxt = S_CHK0;
      S_CHK0: state_nxt = st.hit ? S_FIN : S_RD1;
      S_RD1:  state_nxt = S_CHK1;
      S_CHK1: state_nxt = S_FIN;
      S_FIN: begin
        if (!out_valid_r || !out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      S_IDLE: cmd.load = in_valid;
      S_DIV:  cmd.div_step = 1'b1;
      S_RD0:  cmd.rd_en = 1'b1;
      S_CHK0: cmd.chk = 1'b1;
      S_RD1: begin
        cmd.rd_en = 1'b1;
        cmd.probe_alt = 1'b1;
      end
      S_CHK1: cmd.chk = 1'b1;
      S_FIN:  cmd.out_load = !out_valid_r || !out_stall;
      default: cmd = '0;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

### hdl/htp_dp.sv
// Datapath: size register, bit-serial modulo, slot status, key store, result.
module htp_dp import htp_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  htp_in_t           in_data,
  output htp_out_t          out_data,
  input  logic              cfg_we,
  input  logic [SIZE_W-1:0] cfg_wdata,
  input  ctl_cmd_t          cmd,
  output dp_stat_t          st
);

  localparam int MAX_SIZE = (1 << SIZE_W) - 1;
  localparam int CAP = (TABLE_DEPTH < MAX_SIZE) ? TABLE_DEPTH : MAX_SIZE;
  localparam logic [SIZE_W-1:0] SIZE_CAP = SIZE_W'(CAP);
  localparam int SA_W = $clog2(CAP);
  localparam logic [SIZE_W-1:0] CNT_TOP = SIZE_W'(KEY_W - 1);

  logic [SIZE_W-1:0] tsz_r;
  logic [SIZE_W-1:0] eff;
  logic [1:0]        cmd_r;
  logic [KEY_W-1:0]  key_r;
  logic [SIZE_W-1:0] cnt_r;
  logic [SIZE_W-1:0] rem_r, rem_nxt;
  logic [SIZE_W:0]   rem_sh;
  logic [SIZE_W-1:0] alt;
  logic [SIZE_W-1:0] probe;
  logic [SIZE_W-1:0] p_r;
  slot_st_t          status_r [CAP];
  slot_st_t          cur_st;
  logic [KEY_W-1:0]  ram_rdata;
  logic              hit;
  logic              ins_we;
  htp_out_t          res_r;
  htp_out_t          out_r;

  always_comb begin
    if (tsz_r == '0) begin
      eff = SIZE_W'(1);
    end else if (tsz_r > SIZE_CAP) begin
      eff = SIZE_CAP;
    end else begin
      eff = tsz_r;
    end
  end

  assign rem_sh  = {rem_r, key_r[cnt_r]};
  assign rem_nxt = (rem_sh >= {1'b0, eff}) ? SIZE_W'(rem_sh - {1'b0, eff})
                                           : SIZE_W'(rem_sh);

  assign alt   = (SIZE_W'(rem_r + SIZE_W'(1)) == eff) ? '0 : SIZE_W'(rem_r + SIZE_W'(1));
  assign probe = cmd.probe_alt ? alt : rem_r;

  assign cur_st = status_r[SA_W'(p_r)];

  always_comb begin
    case (cmd_r)
      CMD_INSERT: hit = (cur_st == ST_EMPTY);
      CMD_SEARCH, CMD_REMOVE: hit = (cur_st == ST_OCCUPIED) && (ram_rdata == key_r);
      default: hit = 1'b0;
    endcase
  end

  assign ins_we = cmd.chk && hit && (cmd_r == CMD_INSERT);

  htp_ram #(
    .WIDTH(KEY_W),
    .DEPTH(CAP)
  ) u_keys (
    .clk  (clk),
    .we   (ins_we),
    .waddr(SA_W'(p_r)),
    .wdata(key_r),
    .re   (cmd.rd_en),
    .raddr(SA_W'(probe)),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tsz_r <= SIZE_RST;
      for (int i = 0; i < CAP; i++) begin
        status_r[i] <= ST_EMPTY;
      end
    end else begin
      if (cfg_we) begin
        tsz_r <= cfg_wdata;
      end
      if (cmd.chk && hit) begin
        case (cmd_r)
          CMD_INSERT: status_r[SA_W'(p_r)] <= ST_OCCUPIED;
          CMD_REMOVE: status_r[SA_W'(p_r)] <= ST_DELETED;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r <= in_data.command;
      key_r <= in_data.key;
      cnt_r <= CNT_TOP;
      rem_r <= '0;
      res_r <= '0;
    end
    if (cmd.div_step) begin
      rem_r <= rem_nxt;
      cnt_r <= cnt_r - SIZE_W'(1);
    end
    if (cmd.rd_en) begin
      p_r <= probe;
    end
    if (cmd.chk && hit) begin
      res_r.success    <= 1'b1;
      res_r.slot_index <= p_r[IDX_W-1:0];
    end
    if (cmd.out_load) begin
      out_r <= res_r;
    end
  end

  assign st.div_last = (cnt_r == '0);
  assign st.hit      = hit;
  assign out_data    = out_r;

endmodule

### hdl/htp_checker.sv
// Port-level checks for the hash table core, bound to the top level.
module htp_checker import htp_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input htp_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.success |-> out_data.slot_index == '0)
    else $error("failed result carries nonzero slot");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("not busy after accepting an item");

  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");

endmodule

bind hash_table_two_probe_core htp_checker u_htp_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);
